### hdl/crc_checked_frame_parser_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the frame parser checker.
// Both macros expect clk and rst_n to be visible where they are used.
// ---------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_PARSER_TOP_ASSERT_SVH
`define CRC_CHECKED_FRAME_PARSER_TOP_ASSERT_SVH

// The property must hold in the same cycle as the condition.
`define CFP_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("frame parser check failed in the same cycle");

// The property must hold in the cycle after the condition.
`define CFP_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("frame parser check failed one cycle later");

`endif

### hdl/cfp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame parser package
// Sizes, codes, shared types and the byte-wise CRC16-CCITT update.
// ---------------------------------------------------------------------------
package cfp_pkg;

    localparam int MAX_PAYLOAD_BYTES = 250;
    localparam int CHUNK_BYTES       = 8;
    localparam int STORE_WORDS       = 32;
    localparam int WORD_W            = 64;
    localparam int WORD_IDX_W        = $clog2(STORE_WORDS);
    localparam int LANE_W            = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int CFG_IDX_W         = 2;

    localparam int LEN_CAP_INT =
        ((MAX_PAYLOAD_BYTES + 2) < (STORE_WORDS * CHUNK_BYTES + 2)) ?
        (MAX_PAYLOAD_BYTES + 2) : (STORE_WORDS * CHUNK_BYTES + 2);
    localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_INT);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic [7:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [7:0] HEADER_SECOND_RST = 8'h55;
    localparam logic [7:0] MAX_LENGTH_RST    = 8'd252;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_FIRST  = 2'd0,
        CFG_HEADER_SECOND = 2'd1,
        CFG_MAX_LENGTH    = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_HEAD0    = 3'd0,
        PH_HEAD1    = 3'd1,
        PH_LEN      = 3'd2,
        PH_BODY     = 3'd3,
        PH_CRCH     = 3'd4,
        PH_CRCL     = 3'd5,
        PH_EMIT_RD  = 3'd6,
        PH_EMIT_OUT = 3'd7
    } phase_t;

    typedef struct packed {
        logic                  en;
        logic [WORD_IDX_W-1:0] addr;
        logic [WORD_W-1:0]     data;
    } store_wr_t;

    typedef struct packed {
        logic                  en;
        logic [WORD_IDX_W-1:0] addr;
    } store_rd_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

### hdl/cfp_rx_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Received byte channel
// One byte from the serial link per transaction.
// ---------------------------------------------------------------------------
interface cfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### hdl/cfp_res_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Result channel
// One payload chunk of an accepted frame per transaction.
// ---------------------------------------------------------------------------
interface cfp_res_if
    import cfp_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [7:0]            seq_number;
    logic [7:0]            command_code;
    logic [7:0]            payload_len;
    logic [15:0]           frame_crc;
    logic [WORD_IDX_W-1:0] chunk_index;
    logic [WORD_W-1:0]     chunk_data;
    logic                  last_chunk;

    modport source (output valid, output seq_number, output command_code,
                    output payload_len, output frame_crc, output chunk_index,
                    output chunk_data, output last_chunk, input ready);
    modport sink (input valid, input seq_number, input command_code,
                  input payload_len, input frame_crc, input chunk_index,
                  input chunk_data, input last_chunk, output ready);
endinterface

### hdl/cfp_cfg_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Configuration write channel
// One register write per transaction.
// ---------------------------------------------------------------------------
interface cfp_cfg_if
    import cfp_pkg::*;
    ;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/cfp_payload_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Payload store
// Single-port-write, single-port-read memory of payload words with a
// registered read.
// ---------------------------------------------------------------------------
module cfp_payload_ram
    import cfp_pkg::*;
(
    input  logic              clk,
    input  store_wr_t         wr,
    input  store_rd_t         rd,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] store_mem [STORE_WORDS];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= store_mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/crc_checked_frame_parser_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CRC-checked frame parser
// Hunts for a two-byte header, takes a length byte, sequence, command and
// data bytes and a big-endian CRC16-CCITT, and delivers good frames as
// chunks of eight payload bytes.
//
// The rx channel takes one link byte per transaction, one per cycle while a
// frame is being parsed. Data bytes are packed into words and written to the
// payload memory as each word fills and when the data ends. On the final CRC
// byte the frame is checked; a bad frame is dropped silently. A good frame is
// delivered on the res channel as one transaction per chunk: each chunk is
// first read from the memory and then presented, and the next chunk is read
// only after the current one has been taken. While chunks are pending
// rx.ready is low. When the receiver stalls, the current chunk is held
// unchanged until it is taken. The cfg channel is always ready and should
// only be written while no frame is in progress. Reset restores the header
// bytes and the length limit and returns to the header hunt; the payload
// memory is not cleared, as only words written by the current frame are
// ever read.
// ---------------------------------------------------------------------------
module crc_checked_frame_parser_top
    import cfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    cfp_rx_if.sink   rx,
    cfp_res_if.source res,
    cfp_cfg_if.sink  cfg
);

    localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(CHUNK_BYTES - 1);

    phase_t phase_reg, phase_next;

    logic [7:0] header_first_reg;
    logic [7:0] header_second_reg;
    logic [7:0] max_length_reg;

    logic [7:0]            byte_count_reg, byte_count_next;
    logic [7:0]            frame_length_reg, frame_length_next;
    logic [15:0]           crc_reg, crc_next;
    logic [7:0]            crc_high_reg, crc_high_next;
    logic [7:0]            seq_reg, seq_next;
    logic [7:0]            cmd_reg, cmd_next;
    logic [WORD_W-1:0]     asm_reg, asm_next;
    logic [LANE_W-1:0]     lane_reg, lane_next;
    logic [WORD_IDX_W-1:0] word_reg, word_next;
    logic [15:0]           recv_crc_reg, recv_crc_next;
    logic [7:0]            dlen_reg, dlen_next;
    logic [WORD_IDX_W-1:0] chunk_reg, chunk_next;
    logic [WORD_IDX_W-1:0] last_chunk_reg, last_chunk_next;

    logic              rx_acc;
    logic              res_acc;
    logic [7:0]        b;
    logic [7:0]        len_limit;
    logic              len_ok;
    logic              body_last;
    logic              crc_good;
    logic              is_last;
    logic [7:0]        dlen_calc;
    logic [WORD_W-1:0] asm_base;
    logic [WORD_W-1:0] asm_ins;
    logic [WORD_W-1:0] rd_data;
    store_wr_t         wr_req;
    store_rd_t         rd_req;

    assign b         = rx.rx_byte;
    assign rx_acc    = rx.valid && rx.ready;
    assign res_acc   = res.valid && res.ready;
    assign len_limit = (max_length_reg < LEN_CAP) ? max_length_reg : LEN_CAP;
    assign len_ok    = (b >= 8'd2) && (b <= len_limit);
    assign body_last = ({1'b0, byte_count_reg} + 9'd1) >= {1'b0, frame_length_reg};
    assign crc_good  = ({crc_high_reg, b} == crc_reg);
    assign is_last   = (chunk_reg == last_chunk_reg);
    assign dlen_calc = 8'(frame_length_reg - 8'd2);

    always_comb
    begin
        asm_base = (lane_reg == '0) ? '0 : asm_reg;
        asm_ins  = asm_base;
        for (int g = 0; g < CHUNK_BYTES; g++)
        begin
            if (LANE_W'(g) == lane_reg)
            begin
                asm_ins[g*8 +: 8] = b;
            end
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
            max_length_reg    <= MAX_LENGTH_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_HEADER_FIRST:  header_first_reg  <= cfg.data;
                CFG_HEADER_SECOND: header_second_reg <= cfg.data;
                CFG_MAX_LENGTH:    max_length_reg    <= cfg.data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEAD0:
            begin
                if (rx_acc && (b == header_first_reg))
                begin
                    phase_next = PH_HEAD1;
                end
            end
            PH_HEAD1:
            begin
                if (rx_acc)
                begin
                    priority if (b == header_second_reg)
                    begin
                        phase_next = PH_LEN;
                    end
                    else if (b != header_first_reg)
                    begin
                        phase_next = PH_HEAD0;
                    end
                    else
                    begin
                        phase_next = PH_HEAD1;
                    end
                end
            end
            PH_LEN:
            begin
                if (rx_acc)
                begin
                    phase_next = len_ok ? PH_BODY : PH_HEAD0;
                end
            end
            PH_BODY:
            begin
                if (rx_acc && body_last)
                begin
                    phase_next = PH_CRCH;
                end
            end
            PH_CRCH:
            begin
                if (rx_acc)
                begin
                    phase_next = PH_CRCL;
                end
            end
            PH_CRCL:
            begin
                if (rx_acc)
                begin
                    phase_next = crc_good ? PH_EMIT_RD : PH_HEAD0;
                end
            end
            PH_EMIT_RD:
            begin
                phase_next = PH_EMIT_OUT;
            end
            PH_EMIT_OUT:
            begin
                if (res_acc)
                begin
                    phase_next = is_last ? PH_HEAD0 : PH_EMIT_RD;
                end
            end
            default:
            begin
                phase_next = PH_HEAD0;
            end
        endcase
    end

    always_comb
    begin
        rx.ready  = (phase_reg != PH_EMIT_RD) && (phase_reg != PH_EMIT_OUT);
        res.valid = (phase_reg == PH_EMIT_OUT);
        rd_req.en   = (phase_reg == PH_EMIT_RD) && (dlen_reg != '0);
        rd_req.addr = chunk_reg;
    end

    always_comb
    begin
        byte_count_next   = byte_count_reg;
        frame_length_next = frame_length_reg;
        crc_next          = crc_reg;
        crc_high_next     = crc_high_reg;
        seq_next          = seq_reg;
        cmd_next          = cmd_reg;
        asm_next          = asm_reg;
        lane_next         = lane_reg;
        word_next         = word_reg;
        recv_crc_next     = recv_crc_reg;
        dlen_next         = dlen_reg;
        chunk_next        = chunk_reg;
        last_chunk_next   = last_chunk_reg;
        wr_req            = '0;
        unique case (phase_reg)
            PH_LEN:
            begin
                if (rx_acc && len_ok)
                begin
                    frame_length_next = b;
                    byte_count_next   = '0;
                    crc_next          = CRC_INIT;
                    lane_next         = '0;
                    word_next         = '0;
                end
            end
            PH_BODY:
            begin
                if (rx_acc)
                begin
                    priority if (byte_count_reg == 8'd0)
                    begin
                        seq_next = b;
                    end
                    else if (byte_count_reg == 8'd1)
                    begin
                        cmd_next = b;
                    end
                    else
                    begin
                        asm_next    = asm_ins;
                        wr_req.en   = (lane_reg == LANE_LAST) || body_last;
                        wr_req.addr = word_reg;
                        wr_req.data = asm_ins;
                        if (lane_reg == LANE_LAST)
                        begin
                            lane_next = '0;
                            word_next = word_reg + 1'b1;
                        end
                        else
                        begin
                            lane_next = lane_reg + 1'b1;
                        end
                    end
                    crc_next        = crc16_byte(crc_reg, b);
                    byte_count_next = byte_count_reg + 8'd1;
                end
            end
            PH_CRCH:
            begin
                if (rx_acc)
                begin
                    crc_high_next = b;
                end
            end
            PH_CRCL:
            begin
                if (rx_acc)
                begin
                    recv_crc_next   = {crc_high_reg, b};
                    dlen_next       = dlen_calc;
                    chunk_next      = '0;
                    last_chunk_next = (dlen_calc == '0) ? '0 :
                                      WORD_IDX_W'((dlen_calc - 8'd1) / CHUNK_BYTES);
                end
            end
            PH_EMIT_OUT:
            begin
                if (res_acc && !is_last)
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_count_reg   <= byte_count_next;
        frame_length_reg <= frame_length_next;
        crc_reg          <= crc_next;
        crc_high_reg     <= crc_high_next;
        seq_reg          <= seq_next;
        cmd_reg          <= cmd_next;
        asm_reg          <= asm_next;
        lane_reg         <= lane_next;
        word_reg         <= word_next;
        recv_crc_reg     <= recv_crc_next;
        dlen_reg         <= dlen_next;
        chunk_reg        <= chunk_next;
        last_chunk_reg   <= last_chunk_next;
    end

    cfp_payload_ram u_payload_ram (
        .clk     (clk),
        .wr      (wr_req),
        .rd      (rd_req),
        .rd_data (rd_data)
    );

    assign res.seq_number   = seq_reg;
    assign res.command_code = cmd_reg;
    assign res.payload_len  = dlen_reg;
    assign res.frame_crc    = recv_crc_reg;
    assign res.chunk_index  = chunk_reg;
    assign res.chunk_data   = (dlen_reg == '0) ? '0 : rd_data;
    assign res.last_chunk   = is_last;

endmodule

### hdl/cfp_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame parser port checker
// Watches the handshakes of the top level and checks how result delivery
// and byte intake interleave.
// ---------------------------------------------------------------------------
`include "crc_checked_frame_parser_top_assert.svh"

module cfp_checker
    import cfp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  rx_ready,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic                  res_last_chunk,
    input logic [WORD_IDX_W-1:0] res_chunk_index,
    input logic [WORD_W-1:0]     res_chunk_data
);

    // No byte is taken while a chunk is on offer.
    `CFP_ASSERT_IMP(a_no_rx_during_res, res_valid, !rx_ready)

    // A stalled chunk stays on offer unchanged.
    `CFP_ASSERT_NXT(a_res_hold, res_valid && !res_ready,
                    res_valid && $stable(res_chunk_data) && $stable(res_chunk_index))

    // After a chunk that is not the last, the frame is still being delivered.
    `CFP_ASSERT_NXT(a_more_chunks, res_valid && res_ready && !res_last_chunk, !rx_ready)

    // After the last chunk the parser is back to the header hunt.
    `CFP_ASSERT_NXT(a_ready_after_last, res_valid && res_ready && res_last_chunk, rx_ready)

endmodule

bind crc_checked_frame_parser_top cfp_checker u_cfp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rx_ready        (rx.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_last_chunk  (res.last_chunk),
    .res_chunk_index (res.chunk_index),
    .res_chunk_data  (res.chunk_data)
);
